// ===== design/ray_box_slab_intersection_unit_defines.svh =====
// assertion macros for the ray box slab intersection unit
// expects clk and rst in the scope of each use
`ifndef RAY_BOX_SLAB_INTERSECTION_UNIT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECTION_UNIT_DEFINES_SVH

// condition holds at every edge outside reset
`define RBSI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RBSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rbsi_pkg.sv =====
// shared types and constants for the ray box slab intersection unit
// no dependencies
package rbsi_pkg;

  localparam int CW      = 32;          // coordinate width
  localparam int FB      = 16;          // fraction bits
  localparam int NUMW    = CW + 1;      // magnitude of bound minus origin
  localparam int NW      = NUMW + FB;   // dividend bits, one per divider stage
  localparam int LAT     = NW + 1;      // registers per divider lane: entry plus one per divider stage
  localparam int NUM_AX  = 3;
  localparam int AW      = 5;           // apb address width

  // register indexes
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t          origin_x;
    coord_t          origin_y;
    coord_t          origin_z;
    coord_t          dir_x;
    coord_t          dir_y;
    coord_t          dir_z;
    logic [CW-2:0]   ray_tmax;
  } ray_t;

  typedef struct packed {
    logic   hit;
    coord_t t_enter;
    coord_t t_exit;
  } result_t;

  // per-request data that travels beside the divider lanes
  typedef struct packed {
    logic [CW-2:0]     tmax;
    logic [NUM_AX-1:0] dzero;
    logic [NUM_AX-1:0] pass;
  } side_t;

endpackage

// ===== design/rbsi_div_lane.sv =====
// one divider lane: (bound - origin) * 2^FB / dir, truncated and saturated
// one quotient bit per stage; uses rbsi_pkg and the assertion macro header
`include "ray_box_slab_intersection_unit_defines.svh"

module rbsi_div_lane (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  rbsi_pkg::coord_t bound,
  input  rbsi_pkg::coord_t origin,
  input  rbsi_pkg::coord_t dir,
  output logic            out_valid,
  output rbsi_pkg::coord_t t_plane
);

  localparam int CW   = rbsi_pkg::CW;
  localparam int FB   = rbsi_pkg::FB;
  localparam int NUMW = rbsi_pkg::NUMW;
  localparam int NW   = rbsi_pkg::NW;

  logic            sv   [0:NW];
  logic [CW-1:0]   srem [0:NW];
  logic [NW-1:0]   snum [0:NW];
  logic [NUMW-1:0] sq   [0:NW];
  logic            sovf [0:NW];
  logic [CW-1:0]   sden [0:NW];
  logic            sneg [0:NW];

  logic signed [CW:0] diff;
  logic [CW:0]        dext;
  logic [CW:0]        dmag;
  logic [NUMW-1:0]    nmag;

  // entry: magnitudes and result sign
  assign diff = {bound[CW-1], bound} - {origin[CW-1], origin};
  assign nmag = diff[CW] ? NUMW'(-diff) : NUMW'(diff);
  assign dext = {dir[CW-1], dir};
  assign dmag = dir[CW-1] ? -dext : dext;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srem[0] <= '0;
      snum[0] <= {nmag, {FB{1'b0}}};
      sq[0]   <= '0;
      sovf[0] <= 1'b0;
      sden[0] <= dmag[CW-1:0];
      sneg[0] <= diff[CW] ^ dir[CW-1];
    end
  end

  // restoring division, one bit per stage
  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [CW:0] trial;
    logic        ge;
    logic [CW:0] diffr;

    assign trial = {srem[k-1], snum[k-1][NW-1]};
    assign ge    = trial >= {1'b0, sden[k-1]};
    assign diffr = trial - {1'b0, sden[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= sv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem[k] <= ge ? diffr[CW-1:0] : trial[CW-1:0];
        snum[k] <= {snum[k-1][NW-2:0], 1'b0};
        sq[k]   <= {sq[k-1][NUMW-2:0], ge};
        sovf[k] <= sovf[k-1] | sq[k-1][NUMW-1];
        sden[k] <= sden[k-1];
        sneg[k] <= sneg[k-1];
      end
    end
  end

  // saturation and sign
  logic [NUMW-1:0] lim;
  logic [NUMW-1:0] qs;
  logic [NUMW-1:0] qneg;

  assign lim  = sneg[NW] ? (NUMW'(1) << (CW - 1)) : ((NUMW'(1) << (CW - 1)) - NUMW'(1));
  assign qs   = (sovf[NW] || (sq[NW] > lim)) ? lim : sq[NW];
  assign qneg = -qs;

  assign t_plane   = sneg[NW] ? qneg[CW-1:0] : qs[CW-1:0];
  assign out_valid = sv[NW];

  `RBSI_ASSERT_ALWAYS(a_rem_below_den, !sv[NW] || sden[NW] == '0 || srem[NW] < sden[NW], "divider remainder not below divisor")
  `RBSI_ASSERT_NEXT(a_lane_reset, rst, !sv[0] && !sv[NW], "lane valid not cleared by reset")

endmodule

// ===== design/rbsi_merge.sv =====
// merging stage: orders plane distances per axis and narrows the interval
// registers the result; uses rbsi_pkg and the assertion macro header
`include "ray_box_slab_intersection_unit_defines.svh"

module rbsi_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  rbsi_pkg::side_t  side,
  input  rbsi_pkg::coord_t tlo [0:rbsi_pkg::NUM_AX-1],
  input  rbsi_pkg::coord_t thi [0:rbsi_pkg::NUM_AX-1],
  output logic             out_valid,
  output rbsi_pkg::result_t result
);

  localparam int CW = rbsi_pkg::CW;

  rbsi_pkg::result_t result_next;

  // interval narrowing over x, y, z
  always_comb begin
    rbsi_pkg::coord_t t0;
    rbsi_pkg::coord_t t1;
    rbsi_pkg::coord_t tn;
    rbsi_pkg::coord_t tf;
    logic             h;
    t0 = '0;
    t1 = rbsi_pkg::coord_t'({1'b0, side.tmax});
    tn = '0;
    tf = '0;
    h  = 1'b1;
    for (int a = 0; a < rbsi_pkg::NUM_AX; a++) begin
      if (side.dzero[a]) begin
        if (!side.pass[a]) h = 1'b0;
      end else begin
        tn = (tlo[a] > thi[a]) ? thi[a] : tlo[a];
        tf = (tlo[a] > thi[a]) ? tlo[a] : thi[a];
        if (tn > t0) t0 = tn;
        if (tf < t1) t1 = tf;
        if (t0 > t1) h = 1'b0;
      end
    end
    result_next.hit     = h;
    result_next.t_enter = h ? t0 : '0;
    result_next.t_exit  = h ? t1 : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

  `RBSI_ASSERT_ALWAYS(a_miss_zero, !out_valid || result.hit || (result.t_enter == '0 && result.t_exit == '0), "miss with nonzero distances")
  `RBSI_ASSERT_ALWAYS(a_hit_order, !out_valid || !result.hit || (result.t_enter <= result.t_exit && !result.t_enter[CW-1]), "hit interval out of order")

endmodule

// ===== design/ray_box_slab_intersection_unit.sv =====
// ray against axis-aligned box slab test, top level
// depends on rbsi_pkg, rbsi_div_lane, rbsi_merge and the assertion macro header
//
// usage:
//   box bounds are written over the apb port (box_min_x/y/z at 0x00..0x08,
//   box_max_x/y/z at 0x0c..0x14); pready is always high, reads return the
//   register, writes to other addresses are dropped. write only when idle.
//   ray requests enter on ray_valid/ray_stall/ray; one result per request
//   leaves on hit_valid/hit_stall/result, in request order.
//   the pipeline at Q16.16 has one entry stage, one restoring divider stage
//   per dividend bit and one merge register.
//   six divider lanes (near and far plane on each axis) set the pipeline depth.
//   throughput is one request per cycle while the receiver takes results.
//   when hit_stall is high with a result waiting, the whole pipeline holds
//   and ray_stall goes high; bubbles inside the pipeline stay where they are.
//   reset clears the box registers to zero and all pipeline valid bits.
`include "ray_box_slab_intersection_unit_defines.svh"

module ray_box_slab_intersection_unit (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rbsi_pkg::AW-1:0]   paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // ray requests
  input  logic                      ray_valid,
  output logic                      ray_stall,
  input  rbsi_pkg::ray_t            ray,
  // results
  output logic                      hit_valid,
  input  logic                      hit_stall,
  output rbsi_pkg::result_t         result
);

  localparam int LAT    = rbsi_pkg::LAT;
  localparam int NUM_AX = rbsi_pkg::NUM_AX;

  rbsi_pkg::coord_t box_min [0:NUM_AX-1];
  rbsi_pkg::coord_t box_max [0:NUM_AX-1];
  logic [2:0]       reg_idx;
  logic             en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AX; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        rbsi_pkg::REG_MIN_X: box_min[0] <= pwdata;
        rbsi_pkg::REG_MIN_Y: box_min[1] <= pwdata;
        rbsi_pkg::REG_MIN_Z: box_min[2] <= pwdata;
        rbsi_pkg::REG_MAX_X: box_max[0] <= pwdata;
        rbsi_pkg::REG_MAX_Y: box_max[1] <= pwdata;
        rbsi_pkg::REG_MAX_Z: box_max[2] <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      rbsi_pkg::REG_MIN_X: prdata = box_min[0];
      rbsi_pkg::REG_MIN_Y: prdata = box_min[1];
      rbsi_pkg::REG_MIN_Z: prdata = box_min[2];
      rbsi_pkg::REG_MAX_X: prdata = box_max[0];
      rbsi_pkg::REG_MAX_Y: prdata = box_max[1];
      rbsi_pkg::REG_MAX_Z: prdata = box_max[2];
      default:             prdata = '0;
    endcase
  end

  // global advance: hold everything while a result waits on a stall
  assign en        = !(hit_valid && hit_stall);
  assign ray_stall = !en;

  rbsi_pkg::coord_t org [0:NUM_AX-1];
  rbsi_pkg::coord_t dir [0:NUM_AX-1];

  assign org[0] = ray.origin_x;
  assign org[1] = ray.origin_y;
  assign org[2] = ray.origin_z;
  assign dir[0] = ray.dir_x;
  assign dir[1] = ray.dir_y;
  assign dir[2] = ray.dir_z;

  // side data: parallel-axis checks and tmax
  rbsi_pkg::side_t side_in;
  rbsi_pkg::side_t side_line [0:LAT-1];

  always_comb begin
    side_in.tmax = ray.ray_tmax;
    for (int a = 0; a < NUM_AX; a++) begin
      side_in.dzero[a] = (dir[a] == '0);
      side_in.pass[a]  = (org[a] >= box_min[a]) && (org[a] <= box_max[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= side_in;
      for (int s = 1; s < LAT; s++) side_line[s] <= side_line[s-1];
    end
  end

  // divider lanes: near (min) and far (max) plane per axis
  rbsi_pkg::coord_t tlo [0:NUM_AX-1];
  rbsi_pkg::coord_t thi [0:NUM_AX-1];
  logic [NUM_AX-1:0] lo_valid;
  logic [NUM_AX-1:0] hi_valid;

  for (genvar a = 0; a < NUM_AX; a++) begin : g_axis
    rbsi_div_lane u_lo (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (ray_valid),
      .bound     (box_min[a]),
      .origin    (org[a]),
      .dir       (dir[a]),
      .out_valid (lo_valid[a]),
      .t_plane   (tlo[a])
    );
    rbsi_div_lane u_hi (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (ray_valid),
      .bound     (box_max[a]),
      .origin    (org[a]),
      .dir       (dir[a]),
      .out_valid (hi_valid[a]),
      .t_plane   (thi[a])
    );
  end

  rbsi_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lo_valid[0]),
    .side      (side_line[LAT-1]),
    .tlo       (tlo),
    .thi       (thi),
    .out_valid (hit_valid),
    .result    (result)
  );

  `RBSI_ASSERT_ALWAYS(a_lanes_agree, lo_valid == {NUM_AX{lo_valid[0]}} && hi_valid == lo_valid, "divider lanes out of step")
  `RBSI_ASSERT_NEXT(a_reset_idle, rst, !hit_valid, "result valid after reset")

endmodule
